// ----- hdl/pcg32_pkg.sv -----
// Shared types, constants and the output permutation of the PCG32 generator.
package pcg32_pkg;

  localparam logic [63:0] PCG_MULT      = 64'd6364136223846793005;
  localparam logic [63:0] PCG_STATE_RST = 64'h853c49e6748fea9b;
  localparam logic [63:0] PCG_INC_RST   = 64'hda3e39cb94b95bdb;

  localparam int unsigned LCG_W     = 64;
  localparam int unsigned WORD_W    = 32;
  localparam int unsigned FRAC_W    = 24;
  localparam int unsigned DIGIT_W   = 4;
  localparam int unsigned MUL_STEPS = LCG_W / DIGIT_W;
  localparam int unsigned DIV_STEPS = WORD_W;
  localparam int unsigned PADDR_W   = 4;

  // Register index taken from paddr[3]
  localparam logic REG_SEED   = 1'b0;
  localparam logic REG_STREAM = 1'b1;

  typedef enum logic [1:0] {
    FUNC_RAW    = 2'd0,
    FUNC_FRAC   = 2'd1,
    FUNC_RANGE  = 2'd2,
    FUNC_RESEED = 2'd3
  } func_e;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_RUN  = 3'b010,
    ST_FIN  = 3'b100
  } ctrl_state_e;

  // XSH-RR permutation of the old state
  function automatic logic [WORD_W-1:0] xsh_rr(input logic [LCG_W-1:0] s);
    logic [LCG_W-1:0]  x;
    logic [WORD_W-1:0] xs;
    logic [4:0]        rot;
    x   = ((s >> 18) ^ s) >> 27;
    xs  = x[WORD_W-1:0];
    rot = s[63:59];
    return (xs >> rot) | (xs << (6'd32 - {1'b0, rot}));
  endfunction

endpackage

// ----- hdl/pcg32_if.sv -----
// Request and response channel interfaces of the PCG32 generator.
interface pcg32_req_if;
  logic               valid;
  logic               ready;
  logic [1:0]         func;
  logic signed [31:0] range_low;
  logic signed [31:0] range_high;

  modport source (output valid, func, range_low, range_high, input ready);
  modport sink   (input valid, func, range_low, range_high, output ready);
endinterface

interface pcg32_rsp_if;
  logic               valid;
  logic               ready;
  logic [31:0]        random_word;
  logic [23:0]        unit_fraction;
  logic signed [31:0] ranged_value;

  modport source (output valid, random_word, unit_fraction, ranged_value, input ready);
  modport sink   (input valid, random_word, unit_fraction, ranged_value, output ready);
endinterface

// ----- hdl/pcg32_lcg_mul.sv -----
// Digit-serial LCG step: next = old * multiplier + increment, one nibble a cycle.
module pcg32_lcg_mul (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  input  logic [pcg32_pkg::LCG_W-1:0] old_i,
  input  logic [pcg32_pkg::LCG_W-1:0] inc_i,
  output logic                     done_o,
  output logic [pcg32_pkg::LCG_W-1:0] next_o
);
  import pcg32_pkg::*;

  localparam int unsigned CNT_W = $clog2(MUL_STEPS);

  logic [LCG_W-1:0] acc_q, acc_d;
  logic [LCG_W-1:0] mcand_q, mcand_d;
  logic [LCG_W-1:0] mplier_q, mplier_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             busy_q, busy_d;
  logic             done_q, done_d;

  always_comb begin
    acc_d    = acc_q;
    mcand_d  = mcand_q;
    mplier_d = mplier_q;
    cnt_d    = cnt_q;
    busy_d   = busy_q;
    done_d   = 1'b0;
    if (start_i) begin
      acc_d    = inc_i;
      mcand_d  = PCG_MULT;
      mplier_d = old_i;
      cnt_d    = '0;
      busy_d   = 1'b1;
    end else if (busy_q) begin
      // add one partial product of a nibble, then shift both operands
      acc_d    = acc_q + mcand_q * LCG_W'(mplier_q[DIGIT_W-1:0]);
      mcand_d  = mcand_q << DIGIT_W;
      mplier_d = mplier_q >> DIGIT_W;
      cnt_d    = cnt_q + 1'b1;
      if (cnt_q == CNT_W'(MUL_STEPS - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q    <= acc_d;
    mcand_q  <= mcand_d;
    mplier_q <= mplier_d;
  end

  assign done_o = done_q;
  assign next_o = acc_q;

endmodule

// ----- hdl/pcg32_mod_div.sv -----
// Bit-serial restoring remainder unit: rem = dividend mod divisor.
module pcg32_mod_div (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [pcg32_pkg::WORD_W-1:0] dividend_i,
  input  logic [pcg32_pkg::WORD_W-1:0] divisor_i,
  output logic                        done_o,
  output logic [pcg32_pkg::WORD_W-1:0] rem_o
);
  import pcg32_pkg::*;

  localparam int unsigned CNT_W = $clog2(DIV_STEPS);

  logic [WORD_W-1:0] rem_q, rem_d;
  logic [WORD_W-1:0] dvd_q, dvd_d;
  logic [WORD_W-1:0] dvs_q, dvs_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [WORD_W:0]   trial;

  always_comb begin
    rem_d  = rem_q;
    dvd_d  = dvd_q;
    dvs_d  = dvs_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    trial  = {rem_q, dvd_q[WORD_W-1]};
    if (start_i) begin
      rem_d  = '0;
      dvd_d  = dividend_i;
      dvs_d  = divisor_i;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      // bring in the next dividend bit, subtract where it fits
      if (trial >= {1'b0, dvs_q}) begin
        trial = trial - {1'b0, dvs_q};
      end
      rem_d = trial[WORD_W-1:0];
      dvd_d = dvd_q << 1;
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CNT_W'(DIV_STEPS - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dvd_q <= dvd_d;
    dvs_q <= dvs_d;
  end

  assign done_o = done_q;
  assign rem_o  = rem_q;

endmodule

// ----- hdl/pcg32_random_generator_unit.sv -----
// Top level of the PCG32 XSH-RR generator: config registers, control and output register.
// Raw word, fraction and reseed wait on the 16-step nibble-serial LCG multiplier; a ranged
//   draw also waits on the 32-step bit-serial remainder unit; an empty or inverted range
//   uses neither unit.
// Throughput: one item at a time; the next request beat is taken once the previous result
//   sits in the output register, so it overlaps with the wait for the consumer.
// Reset: LCG state and increment return to the stock PCG32 defaults, seed and stream to 0.
module pcg32_random_generator_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  pcg32_req_if.sink                     req_i,
  pcg32_rsp_if.source                   rsp_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [pcg32_pkg::PADDR_W-1:0] paddr,
  input  logic [63:0]                   pwdata,
  output logic [63:0]                   prdata,
  output logic                          pready
);
  import pcg32_pkg::*;

  // Configuration registers
  logic [63:0] seed_q, stream_q;

  // Generator state
  logic [LCG_W-1:0] lcg_state_q, lcg_state_d;
  logic [LCG_W-1:0] lcg_inc_q, lcg_inc_d;

  // Per-item working registers
  ctrl_state_e       state_q, state_d;
  func_e             func_q, func_d;
  logic [WORD_W-1:0] word_q, word_d;
  logic [WORD_W-1:0] lo_q, lo_d;
  logic [WORD_W-1:0] span_q, span_d;
  logic              empty_q, empty_d;
  logic              mul_pend_q, mul_pend_d;
  logic              div_pend_q, div_pend_d;

  // Output register
  logic              out_valid_q, out_valid_d;
  logic [WORD_W-1:0] out_word_q, out_word_d;
  logic [FRAC_W-1:0] out_frac_q, out_frac_d;
  logic [WORD_W-1:0] out_ranged_q, out_ranged_d;

  // Serial units
  logic              mul_start, mul_done;
  logic [LCG_W-1:0]  mul_old, mul_inc, mul_next;
  logic              div_start, div_done;
  logic [WORD_W-1:0] div_rem;

  logic              accept;
  logic              out_free;
  func_e             req_func;
  logic [63:0]       mix;
  logic [LCG_W-1:0]  reseed_inc;
  logic [LCG_W-1:0]  reseed_state;
  logic [WORD_W-1:0] draw_word;
  logic [WORD_W-1:0] req_span;
  logic [WORD_W-1:0] offset;
  logic              cfg_write;

  // ---------------------------------------------------------------------------
  // APB port: always ready, register selected by paddr[3]
  // ---------------------------------------------------------------------------
  assign pready    = 1'b1;
  assign cfg_write = psel & penable & pwrite & pready;
  assign prdata    = (paddr[3] == REG_STREAM) ? stream_q : seed_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seed_q   <= '0;
      stream_q <= '0;
    end else if (cfg_write) begin
      unique case (paddr[3])
        REG_SEED:   seed_q   <= pwdata;
        REG_STREAM: stream_q <= pwdata;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Request decode
  // ---------------------------------------------------------------------------
  assign req_i.ready = (state_q == ST_IDLE);
  assign accept      = req_i.valid & req_i.ready;
  assign req_func    = func_e'(req_i.func);

  // Permuted word taken from the current state before it advances
  assign draw_word = xsh_rr(lcg_state_q);
  assign req_span  = req_i.range_high - req_i.range_low + 32'd1;

  // Reseed: the first step from a zero state lands on the increment itself,
  // so fold it in with the state offset and run only the second step serially
  assign mix          = seed_q ^ stream_q;
  assign reseed_inc   = {mix[62:0], 1'b1};
  assign reseed_state = reseed_inc + (PCG_STATE_RST ^ mix);

  assign mul_old   = (req_func == FUNC_RESEED) ? reseed_state : lcg_state_q;
  assign mul_inc   = (req_func == FUNC_RESEED) ? reseed_inc : lcg_inc_q;
  assign div_start = accept && (req_func == FUNC_RANGE) &&
                     !(req_i.range_high <= req_i.range_low);
  assign mul_start = accept && !((req_func == FUNC_RANGE) &&
                     (req_i.range_high <= req_i.range_low));

  pcg32_lcg_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .old_i   (mul_old),
    .inc_i   (mul_inc),
    .done_o  (mul_done),
    .next_o  (mul_next)
  );

  pcg32_mod_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (draw_word),
    .divisor_i  (req_span),
    .done_o     (div_done),
    .rem_o      (div_rem)
  );

  // A span that wrapped to zero means the full 32-bit range: use the raw word
  assign offset   = (span_q == '0) ? word_q : div_rem;
  assign out_free = !out_valid_q || rsp_o.ready;

  // ---------------------------------------------------------------------------
  // Control
  // ---------------------------------------------------------------------------
  always_comb begin
    state_d      = state_q;
    func_d       = func_q;
    word_d       = word_q;
    lo_d         = lo_q;
    span_d       = span_q;
    empty_d      = empty_q;
    mul_pend_d   = mul_pend_q;
    div_pend_d   = div_pend_q;
    lcg_state_d  = lcg_state_q;
    lcg_inc_d    = lcg_inc_q;
    out_valid_d  = out_valid_q;
    out_word_d   = out_word_q;
    out_frac_d   = out_frac_q;
    out_ranged_d = out_ranged_q;

    // drop the result once the consumer takes the beat
    if (out_valid_q && rsp_o.ready) begin
      out_valid_d = 1'b0;
    end

    // store the advanced state when the multiplier finishes
    if (mul_done) begin
      lcg_state_d = mul_next;
      mul_pend_d  = 1'b0;
    end
    if (div_done) begin
      div_pend_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          func_d     = req_func;
          lo_d       = req_i.range_low;
          span_d     = req_span;
          empty_d    = 1'b0;
          word_d     = draw_word;
          mul_pend_d = mul_start;
          div_pend_d = div_start;
          state_d    = ST_RUN;
          unique case (req_func)
            FUNC_RAW, FUNC_FRAC: ;
            FUNC_RANGE: begin
              if (req_i.range_high <= req_i.range_low) begin
                empty_d = 1'b1;
                word_d  = '0;
              end
            end
            FUNC_RESEED: begin
              word_d      = '0;
              lcg_inc_d   = reseed_inc;
              lcg_state_d = reseed_state;
            end
            default: ;
          endcase
        end
      end
      ST_RUN: begin
        if (!mul_pend_q && !div_pend_q) begin
          state_d = ST_FIN;
        end
      end
      ST_FIN: begin
        // hold until the output register is free, then load the result
        if (out_free) begin
          out_valid_d  = 1'b1;
          out_word_d   = word_q;
          out_frac_d   = (func_q == FUNC_FRAC) ? word_q[WORD_W-1:WORD_W-FRAC_W] : '0;
          out_ranged_d = '0;
          if (func_q == FUNC_RANGE) begin
            out_ranged_d = empty_q ? lo_q : lo_q + offset;
          end
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      mul_pend_q  <= 1'b0;
      div_pend_q  <= 1'b0;
      out_valid_q <= 1'b0;
      lcg_state_q <= PCG_STATE_RST;
      lcg_inc_q   <= PCG_INC_RST;
    end else begin
      state_q     <= state_d;
      mul_pend_q  <= mul_pend_d;
      div_pend_q  <= div_pend_d;
      out_valid_q <= out_valid_d;
      lcg_state_q <= lcg_state_d;
      lcg_inc_q   <= lcg_inc_d;
    end
  end

  always_ff @(posedge clk_i) begin
    func_q       <= func_d;
    word_q       <= word_d;
    lo_q         <= lo_d;
    span_q       <= span_d;
    empty_q      <= empty_d;
    out_word_q   <= out_word_d;
    out_frac_q   <= out_frac_d;
    out_ranged_q <= out_ranged_d;
  end

  assign rsp_o.valid         = out_valid_q;
  assign rsp_o.random_word   = out_word_q;
  assign rsp_o.unit_fraction = out_frac_q;
  assign rsp_o.ranged_value  = out_ranged_q;

endmodule
